// ----- sv/rfs_pkg.sv -----
// Shared constants and types for the ring FIFO with search.
`default_nettype none

package rfs_pkg;

    // Default build sizes
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths on the ports
    localparam int ACTION_W    = 2;
    localparam int WORD_W      = 32;
    localparam int CAP_W       = 5;
    localparam int OCC_W       = 5;
    localparam int OUT_TDATA_W = 40;

    // Capacity after reset, before clamping to the built depth
    localparam int CAP_RESET = 16;

    // Request kinds carried on the input tuser
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_SEARCH = 2'd2
    } t_action;

    // Memory port strobes from the sequencer to the store
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

`default_nettype wire

// ----- sv/ring_fifo_with_search.sv -----
// Top level of the ring FIFO with search.
//
//  channel  | direction | signals                         | payload
//  ---------+-----------+---------------------------------+------------------------------
//  cfg      | in        | i_cfg_valid/o_cfg_ready         | i_cfg_data: capacity
//  s        | in        | i_s_tvalid/o_s_tready           | tuser: action, tdata: data_in
//  m        | out       | o_m_tvalid/i_m_tready           | tuser: ok, tdata: data_out, occ
//
// Result is valid in the cycle after the request transfer for a push, a refused pop,
// an unused code or a search of an empty FIFO; a pop passes through ST_POP (one registered
// read), a search through ST_SRCH (one stored entry compared per cycle) before ST_DONE.
// The result then waits on o_m_tready, and the block returns to idle after its
// transfer; one request is in flight at a time. Synchronous active-low reset
// empties the FIFO, capacity 16 clamped to DEPTH; a capacity write also empties it.
`default_nettype none

module ring_fifo_with_search #(
    parameter int DEPTH      = rfs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rfs_pkg::DATA_WIDTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // capacity register write
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [rfs_pkg::CAP_W-1:0]          i_cfg_data,
    // requests
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire  [rfs_pkg::WORD_W-1:0]         i_s_tdata,   // [31:0] data_in
    input  wire  [rfs_pkg::ACTION_W-1:0]       i_s_tuser,   // [1:0] action
    // results
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    output logic [rfs_pkg::OUT_TDATA_W-1:0]    o_m_tdata,   // [31:0] data_out, [36:32] occupancy
    output logic                               o_m_tuser    // [0] ok
);
    import rfs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_mem_ctl              w_ctl;
    logic [AW-1:0]         w_waddr;
    logic [AW-1:0]         w_raddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [DATA_WIDTH-1:0] w_key;
    logic [DATA_WIDTH-1:0] w_rdata;
    logic                  w_match;
    logic [WORD_W-1:0]     w_dout;
    logic [OCC_W-1:0]      w_occ;

    rfs_seq #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .CW         (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_action    (i_s_tuser),
        .i_data_in   (i_s_tdata),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_ok        (o_m_tuser),
        .o_data_out  (w_dout),
        .o_occupancy (w_occ),
        .o_ctl       (w_ctl),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .o_key       (w_key),
        .i_rdata     (w_rdata),
        .i_match     (w_match)
    );

    rfs_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .i_key   (w_key),
        .o_rdata (w_rdata),
        .o_match (w_match)
    );

    // Result packing, zero padded to whole bytes
    assign o_m_tdata = {{(OUT_TDATA_W - OCC_W - WORD_W){1'b0}}, w_occ, w_dout};

endmodule

`default_nettype wire

// ----- sv/rfs_store.sv -----
// Slot memory with registered read port and the shared word comparator.
`default_nettype none

module rfs_store #(
    parameter int DEPTH      = rfs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rfs_pkg::DATA_WIDTH_DEF,
    parameter int AW         = 4
) (
    input  wire                   i_clk,
    input  rfs_pkg::t_mem_ctl     i_ctl,
    input  wire  [AW-1:0]         i_waddr,
    input  wire  [DATA_WIDTH-1:0] i_wdata,
    input  wire  [AW-1:0]         i_raddr,
    input  wire  [DATA_WIDTH-1:0] i_key,
    output logic [DATA_WIDTH-1:0] o_rdata,
    output logic                  o_match
);
    import rfs_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    // Single write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Single read port, data registered
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

    // Comparator shared by every step of a search
    assign o_match = (r_rdata == i_key);

endmodule

`default_nettype wire

// ----- sv/rfs_seq.sv -----
// Request sequencer: pointers, fill count, capacity and the result register.
`default_nettype none

module rfs_seq #(
    parameter int DEPTH      = rfs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rfs_pkg::DATA_WIDTH_DEF,
    parameter int AW         = 4,
    parameter int CW         = 5
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // capacity write
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [rfs_pkg::CAP_W-1:0]     i_cfg_data,
    // request
    input  wire                           i_req_valid,
    output logic                          o_req_ready,
    input  wire  [rfs_pkg::ACTION_W-1:0]  i_action,
    input  wire  [rfs_pkg::WORD_W-1:0]    i_data_in,
    // result
    output logic                          o_res_valid,
    input  wire                           i_res_ready,
    output logic                          o_ok,
    output logic [rfs_pkg::WORD_W-1:0]    o_data_out,
    output logic [rfs_pkg::OCC_W-1:0]     o_occupancy,
    // store
    output rfs_pkg::t_mem_ctl             o_ctl,
    output logic [AW-1:0]                 o_waddr,
    output logic [DATA_WIDTH-1:0]         o_wdata,
    output logic [AW-1:0]                 o_raddr,
    output logic [DATA_WIDTH-1:0]         o_key,
    input  wire  [DATA_WIDTH-1:0]         i_rdata,
    input  wire                           i_match
);
    import rfs_pkg::*;

    localparam int RST_CAP = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_POP  = 4'b0010,
        ST_SRCH = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_eff_cap, n_eff_cap;
    logic [AW-1:0]         r_wp, n_wp;
    logic [AW-1:0]         r_rp, n_rp;
    logic [CW-1:0]         r_fill, n_fill;
    logic [AW-1:0]         r_ptr, n_ptr;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [DATA_WIDTH-1:0] r_key, n_key;
    logic                  r_ok, n_ok;
    logic [WORD_W-1:0]     r_dout, n_dout;

    logic                        w_cfg_fire;
    logic                        w_req_fire;
    logic [31:0]                 w_cfg_ext;
    logic [31:0]                 w_eff32;
    logic [DATA_WIDTH+WORD_W-1:0] w_din_ext;
    logic [DATA_WIDTH+WORD_W-1:0] w_rd_ext;
    logic [CW+OCC_W-1:0]         w_occ_ext;
    logic [DATA_WIDTH-1:0]       w_word;

    // Next position, wrapping at the effective capacity
    function automatic logic [AW-1:0] f_adv(input logic [AW-1:0] pos,
                                            input logic [CW-1:0] cap);
        logic [CW-1:0] nxt;
        nxt = CW'(pos) + CW'(1);
        return (nxt >= cap) ? '0 : nxt[AW-1:0];
    endfunction

    assign w_cfg_fire = i_cfg_valid && o_cfg_ready;
    assign w_req_fire = i_req_valid && o_req_ready;

    // Clamp capacity: zero acts as one, above depth acts as depth
    assign w_cfg_ext = 32'(i_cfg_data);
    assign w_eff32   = (w_cfg_ext == 32'd0) ? 32'd1 :
                       (w_cfg_ext > 32'(DEPTH)) ? 32'(DEPTH) : w_cfg_ext;

    // Word size conversions between ports and storage
    assign w_din_ext = {{DATA_WIDTH{1'b0}}, i_data_in};
    assign w_word    = w_din_ext[DATA_WIDTH-1:0];
    assign w_rd_ext  = {{WORD_W{1'b0}}, i_rdata};
    assign w_occ_ext = {{OCC_W{1'b0}}, r_fill};

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_eff_cap = r_eff_cap;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_fill    = r_fill;
        n_ptr     = r_ptr;
        n_cnt     = r_cnt;
        n_key     = r_key;
        n_ok      = r_ok;
        n_dout    = r_dout;
        o_ctl     = '0;
        o_raddr   = r_rp;
        case (r_state)
            ST_IDLE: begin
                if (w_cfg_fire) begin
                    n_eff_cap = w_eff32[CW-1:0];
                    n_wp      = '0;
                    n_rp      = '0;
                    n_fill    = '0;
                end else if (w_req_fire) begin
                    n_ok    = 1'b0;
                    n_dout  = '0;
                    n_state = ST_DONE;
                    case (t_action'(i_action))
                        ACT_PUSH: begin
                            if (r_fill < r_eff_cap) begin
                                o_ctl.we = 1'b1;
                                n_wp     = f_adv(r_wp, r_eff_cap);
                                n_fill   = r_fill + CW'(1);
                                n_ok     = 1'b1;
                            end
                        end
                        ACT_POP: begin
                            if (r_fill != '0) begin
                                o_ctl.re = 1'b1;
                                n_state  = ST_POP;
                            end
                        end
                        ACT_SEARCH: begin
                            if (r_fill != '0) begin
                                o_ctl.re = 1'b1;
                                n_ptr    = f_adv(r_rp, r_eff_cap);
                                n_cnt    = r_fill;
                                n_key    = w_word;
                                n_state  = ST_SRCH;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_POP: begin
                n_dout  = w_rd_ext[WORD_W-1:0];
                n_rp    = f_adv(r_rp, r_eff_cap);
                n_fill  = r_fill - CW'(1);
                n_ok    = 1'b1;
                n_state = ST_DONE;
            end
            ST_SRCH: begin
                // compare the entry read last cycle, fetch the next one
                if (i_match) begin
                    n_ok    = 1'b1;
                    n_state = ST_DONE;
                end else if (r_cnt == CW'(1)) begin
                    n_state = ST_DONE;
                end else begin
                    o_ctl.re = 1'b1;
                    o_raddr  = r_ptr;
                    n_ptr    = f_adv(r_ptr, r_eff_cap);
                    n_cnt    = r_cnt - CW'(1);
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_eff_cap <= CW'(RST_CAP);
            r_wp      <= '0;
            r_rp      <= '0;
            r_fill    <= '0;
            r_ptr     <= '0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_eff_cap <= n_eff_cap;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_fill    <= n_fill;
            r_ptr     <= n_ptr;
            r_cnt     <= n_cnt;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_ok   <= n_ok;
        r_dout <= n_dout;
    end

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_req_ready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_res_valid = (r_state == ST_DONE);
    assign o_ok        = r_ok;
    assign o_data_out  = r_dout;
    assign o_occupancy = w_occ_ext[OCC_W-1:0];
    assign o_waddr     = r_wp;
    assign o_wdata     = w_word;
    assign o_key       = r_key;

endmodule

`default_nettype wire

// ----- sv/rfs_checker.sv -----
// Port-level checks for the ring FIFO with search, bound to the top level.
`default_nettype none

module rfs_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              o_cfg_ready,
    input wire                              i_s_tvalid,
    input wire                              o_s_tready,
    input wire                              o_m_tvalid,
    input wire                              i_m_tready,
    input wire [rfs_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    input wire                              o_m_tuser
);
    import rfs_pkg::*;

    // A pending result holds until transferred
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("result dropped or changed while stalled");

    // No new request while a result waits
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (!o_s_tready && !o_cfg_ready))
        else $error("request or config taken while result pending");

    // A request transfer closes the input side in the following cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready right after a request transfer");

    // A failed result carries a zero data word
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[WORD_W-1:0] == '0))
        else $error("nonzero data on a failed result");

endmodule

bind ring_fifo_with_search rfs_checker u_rfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_cfg_ready (o_cfg_ready),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser)
);

`default_nettype wire

// ----- dv/tb_ring_fifo_with_search.sv -----
// Testbench for the ring FIFO with search: directed and random requests, scoreboard check.
`timescale 1ns / 100ps

module tb_ring_fifo_with_search;

    import rfs_pkg::*;

    localparam int          CLK_HALF    = 2;
    localparam int          RST_CYCLES  = 9;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          TAIL_CYCLES = 40;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;

    // One response as the block reports it
    typedef struct packed {
        logic             ok;
        logic [31:0]      data;
        logic [OCC_W-1:0] occ;
    } t_response;

    // Clock, reset and block inputs, all known from time zero
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CAP_W-1:0]       i_cfg_data  = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic [WORD_W-1:0]      i_s_tdata   = '0;   // [31:0] data_in
    logic [ACTION_W-1:0]    i_s_tuser   = '0;   // [1:0] action
    logic                   i_m_tready  = 1'b0;

    logic                   o_cfg_ready;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;          // [31:0] data_out, [36:32] occupancy
    logic                   o_m_tuser;          // [0] ok

    // Shadow copy of the FIFO state
    logic [31:0]            fifo_words [DEPTH_DEF];
    logic [3:0]             wr_ptr;
    logic [3:0]             rd_ptr;
    logic [OCC_W-1:0]       fill_cnt;
    logic [CAP_W-1:0]       cap_reg;

    t_response              pending_responses [$];
    int                     fail_cnt  = 0;
    int                     cycle_cnt = 0;
    bit                     idle_on   = 1'b0;

    ring_fifo_with_search u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Capacity as the block applies it: zero acts as one, clamp at the depth
    function automatic int active_cap();
        if (cap_reg == 0)
            return 1;
        if (cap_reg > DEPTH_DEF)
            return DEPTH_DEF;
        return int'(cap_reg);
    endfunction

    function automatic logic [3:0] next_pos(input logic [3:0] pos);
        int n;
        n = int'(pos) + 1;
        return (n >= active_cap()) ? 4'd0 : n[3:0];
    endfunction

    // Apply one request to the shadow state and return the response it yields
    function automatic t_response compute_response(input logic [1:0] act,
                                                   input logic [31:0] word);
        t_response  res;
        logic [3:0] pos;
        int         k;
        res = '0;
        case (act)
            ACT_PUSH: begin
                if (fill_cnt < active_cap()) begin
                    fifo_words[wr_ptr] = word;
                    wr_ptr   = next_pos(wr_ptr);
                    fill_cnt = fill_cnt + 1'b1;
                    res.ok   = 1'b1;
                end
            end
            ACT_POP: begin
                if (fill_cnt != 0) begin
                    res.data = fifo_words[rd_ptr];
                    rd_ptr   = next_pos(rd_ptr);
                    fill_cnt = fill_cnt - 1'b1;
                    res.ok   = 1'b1;
                end
            end
            ACT_SEARCH: begin
                // walk the occupied entries from the read side, wrapping at capacity
                pos = rd_ptr;
                for (k = 0; k < fill_cnt && !res.ok; k++) begin
                    if (fifo_words[pos] == word)
                        res.ok = 1'b1;
                    pos = next_pos(pos);
                end
            end
            default: ;
        endcase
        res.occ = fill_cnt;
        return res;
    endfunction

    // Result receiver: random stall bursts while idling is enabled
    always begin
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_m_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_m_tready <= 1'b1;
    end

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (exp_val !== got_val) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, exp_val, got_val);
            fail_cnt++;
        end
    endtask

    // Compare each result transfer with the oldest pending response
    always @(posedge i_clk) begin
        t_response exp_res;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_responses.size() == 0) begin
                $display("%0t: unexpected result, expected none, got ok=%0b data=0x%0h occ=%0d",
                         $time, o_m_tuser, o_m_tdata[31:0], o_m_tdata[36:32]);
                fail_cnt++;
            end else begin
                exp_res = pending_responses.pop_front();
                check_field("ok", 32'(exp_res.ok), 32'(o_m_tuser));
                check_field("data_out", exp_res.data, o_m_tdata[31:0]);
                check_field("occupancy", 32'(exp_res.occ), 32'(o_m_tdata[36:32]));
            end
        end
    end

    // Send one request; called and returns at a falling edge
    task automatic send_req(input logic [1:0] act, input logic [31:0] word);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= word;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        pending_responses.push_back(compute_response(act, word));
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every response has come back
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Capacity write while the block is idle; it also empties the FIFO
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        cap_reg  = value;
        wr_ptr   = '0;
        rd_ptr   = '0;
        fill_cnt = '0;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Empty FIFO after reset, unused code, hit and miss, refused pop
    task automatic test_reset_state();
        send_req(ACT_POP, 32'h0);
        send_req(ACT_SEARCH, 32'h0);
        send_req(ACT_UNUSED, 32'hFFFF_FFFF);
        send_req(ACT_PUSH, 32'h0000_0000);
        send_req(ACT_PUSH, 32'hFFFF_FFFF);
        send_req(ACT_SEARCH, 32'hFFFF_FFFF);
        send_req(ACT_SEARCH, 32'h0000_0001);
        send_req(ACT_POP, 32'h1234_5678);
        send_req(ACT_UNUSED, 32'h0);
        send_req(ACT_POP, 32'h0);
        send_req(ACT_POP, 32'h0);
    endtask

    // Capacity one and zero (which acts as one): second push refused
    task automatic test_capacity_edges();
        write_capacity(5'd1);
        send_req(ACT_PUSH, 32'hA5A5_A5A5);
        send_req(ACT_PUSH, 32'h5A5A_5A5A);
        send_req(ACT_SEARCH, 32'hA5A5_A5A5);
        send_req(ACT_POP, 32'h0);
        write_capacity(5'd0);
        send_req(ACT_PUSH, 32'h8000_0000);
        send_req(ACT_PUSH, 32'h0000_0001);
        send_req(ACT_POP, 32'h0);
    endtask

    // Small capacity: positions wrap and the search follows the wrap
    task automatic test_wraparound();
        write_capacity(5'd3);
        send_req(ACT_PUSH, 32'h1111_1111);
        send_req(ACT_PUSH, 32'h2222_2222);
        send_req(ACT_PUSH, 32'h3333_3333);
        send_req(ACT_POP, 32'h0);
        send_req(ACT_PUSH, 32'h4444_4444);
        send_req(ACT_SEARCH, 32'h4444_4444);
        send_req(ACT_SEARCH, 32'h1111_1111);
    endtask

    // Random request mix; push_pct biases toward filling or emptying
    task automatic random_requests(input int n_items, input int push_pct);
        int          r;
        int          k;
        logic [1:0]  act;
        logic [31:0] word;
        logic [3:0]  pos;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
                act = ACT_PUSH;
            else if (r < push_pct + (90 - push_pct) / 2)
                act = ACT_POP;
            else if (r < 97)
                act = ACT_SEARCH;
            else
                act = ACT_UNUSED;
            word = $urandom();
            if (act == ACT_SEARCH && fill_cnt != 0 && $urandom_range(0, 1) == 0) begin
                // pick a stored word so that the search hits
                k   = $urandom_range(0, fill_cnt - 1);
                pos = rd_ptr;
                repeat (k) pos = next_pos(pos);
                word = fifo_words[pos];
            end else if ($urandom_range(0, 3) == 0) begin
                // narrow pool to make duplicates and near misses likely
                word = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 13'h0,
                        3'($urandom_range(0, 7))};
            end
            send_req(act, word);
        end
    endtask

    // Random traffic over a spread of capacities, with idling
    task automatic test_random_traffic();
        logic [CAP_W-1:0] caps [10];
        caps = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd2, 5'd8, 5'($urandom_range(0, 31)),
                 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), 5'd15};
        idle_on = 1'b1;
        foreach (caps[i]) begin
            write_capacity(caps[i]);
            random_requests(60, 65);
            random_requests(45, 25);
        end
    endtask

    // Back-to-back traffic with neither side idling
    task automatic test_back_to_back();
        idle_on = 1'b0;
        write_capacity(5'($urandom_range(0, 31)));
        random_requests(60, 65);
        random_requests(45, 25);
        write_capacity(5'd16);
        random_requests(60, 65);
        random_requests(45, 25);
    endtask

    initial begin
        cap_reg  = 5'(CAP_RESET);
        wr_ptr   = '0;
        rd_ptr   = '0;
        fill_cnt = '0;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_capacity_edges();
        test_wraparound();
        test_random_traffic();
        test_back_to_back();

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
sv/rfs_pkg.sv
sv/rfs_store.sv
sv/rfs_seq.sv
sv/ring_fifo_with_search.sv
sv/rfs_checker.sv
dv/tb_ring_fifo_with_search.sv
